/* rtl/gcmp_pkg.sv */
// Package: request codes, state types and gamma constants for the PWM unit.
package gcmp_pkg;

  localparam int unsigned NumCh     = 8;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned CycleW    = 20;
  localparam int unsigned DutyW     = 15;
  localparam int unsigned ValW      = 16;
  localparam int unsigned TimeW     = 32;
  localparam logic [CycleW-1:0] CycleRst = 20'd10000;
  localparam logic [DutyW-1:0]  DutyRst  = 15'd255;
  // ceil(2^26 / 5), exact quotient for dividends below 2^26
  localparam logic [23:0] Recip5 = 24'd13421773;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_DUTY   = 2'd1,
    REQ_LEVEL  = 2'd2,
    REQ_RECOMP = 2'd3
  } gcmp_req_e;

  typedef enum logic {
    CFG_CYCLE = 1'b0,
    CFG_DMAX  = 1'b1
  } gcmp_cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DUTY_WAIT,
    ST_RC_SCAN,
    ST_RC_WAIT
  } gcmp_st_e;

  typedef enum logic [3:0] {
    G_IDLE,
    G_DIV,
    G_NORM,
    G_SQR,
    G_SCL,
    G_DIV5,
    G_EXP,
    G_SHF,
    G_MUL
  } gcmp_gst_e;

  typedef struct packed {
    logic [DutyW-1:0]  target;
    logic [DutyW-1:0]  maxv;
    logic [CycleW-1:0] cycle;
  } gcmp_greq_t;

  function automatic logic [63:0] gcmp_isqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bv;
    logic [63:0] x;
    res = '0;
    bv  = 64'd1 << 62;
    x   = v;
    for (int i = 0; i < 32; i++) begin
      if (x >= res + bv) begin
        x   = x - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  // Q30 root 2^-(2^-j)
  function automatic logic [63:0] gcmp_c(input int j);
    logic [63:0] c;
    c = 64'd1 << 29;
    for (int i = 0; i < j; i++) begin
      c = gcmp_isqrt(c << 30);
    end
    return c;
  endfunction

endpackage

/* rtl/gcmp_if.sv */
// Interfaces: request channel and pin word channel.
interface gcmp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [2:0]  channel;
  logic [15:0] level_value;
  logic [31:0] now_us;
  modport source (output valid, req_type, channel, level_value, now_us, input ready);
  modport sink (input valid, req_type, channel, level_value, now_us, output ready);
endinterface

interface gcmp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pin_levels;
  modport source (output valid, pin_levels, input ready);
  modport sink (input valid, pin_levels, output ready);
endinterface

/* rtl/gamma_corrected_multichannel_pwm_unit.sv */
// Top level: eight-pin level/PWM driver with gamma-corrected duty.
// Tick and level requests finish when taken; a tick that changes the pins sends
// its word the cycle after. A duty request runs the gamma unit (16-step divider,
// up to 15 normalize steps, 16 squarings, 16 root products on one multiplier).
// A recompute runs the gamma unit once per enabled channel.
// Reset is asynchronous active low: all pins low, PWM off, registers at defaults.
module gamma_corrected_multichannel_pwm_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  gcmp_req_if.sink    req,
  gcmp_out_if.source  out,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [19:0] cfg_wdata_i
);
  import gcmp_pkg::*;

  gcmp_st_e          st_q, st_d;
  logic [2:0]        ch_q, ch_d;
  logic [CycleW-1:0] cyc_q;
  logic [DutyW-1:0]  dmax_q;
  logic [DutyW-1:0]  tgt_q [NumCh];
  logic [CycleW-1:0] ont_q [NumCh];
  logic [NumCh-1:0]  en_q, en_d, hp_q, hp_d;
  logic [7:0]        pin_q, pin_d, last_q, last_d, odata_q, odata_d;
  logic [TimeW-1:0]  cstart_q, cstart_d;
  logic              ovld_q, ovld_d;

  logic              acc;
  logic              tgt_we;
  logic [DutyW-1:0]  clamp;
  logic              gstart;
  gcmp_greq_t        greq;
  logic              gdone;
  logic [CycleW-1:0] gres;

  logic [TimeW-1:0]  elapsed, el2;
  logic              newc;
  logic [NumCh-1:0]  tk_hp;
  logic [7:0]        tk_pin;

  assign req.ready = (st_q == ST_IDLE) && (!ovld_q || out.ready);
  assign acc       = req.valid && req.ready;
  assign clamp     = (req.level_value < {1'b0, dmax_q}) ? req.level_value[DutyW-1:0] : dmax_q;

  gcmp_gamma u_gamma (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (gstart),
    .req_i     (greq),
    .done_o    (gdone),
    .on_time_o (gres)
  );

  assign elapsed = req.now_us - cstart_q;
  assign newc    = elapsed >= {12'd0, cyc_q};
  assign el2     = newc ? '0 : elapsed;

  always_comb begin
    tk_hp  = hp_q;
    tk_pin = pin_q;
    for (int i = 0; i < NumCh; i++) begin
      if (en_q[i] && newc) begin
        tk_hp[i]  = ont_q[i] != '0;
        tk_pin[i] = ont_q[i] != '0;
      end
      if (en_q[i] && tk_hp[i] && el2 >= {12'd0, ont_q[i]} && ont_q[i] < cyc_q) begin
        tk_hp[i]  = 1'b0;
        tk_pin[i] = 1'b0;
      end
    end
  end

  always_comb begin
    st_d     = st_q;
    ch_d     = ch_q;
    en_d     = en_q;
    hp_d     = hp_q;
    pin_d    = pin_q;
    last_d   = last_q;
    odata_d  = odata_q;
    cstart_d = cstart_q;
    ovld_d   = ovld_q && !out.ready;
    tgt_we   = 1'b0;
    gstart   = 1'b0;
    greq     = '{target: tgt_q[ch_q], maxv: dmax_q, cycle: cyc_q};
    unique case (st_q)
      ST_IDLE: begin
        if (acc) begin
          ch_d = req.channel;
          unique case (gcmp_req_e'(req.req_type))
            REQ_DUTY: begin
              en_d[req.channel] = 1'b1;
              tgt_we            = 1'b1;
              gstart            = 1'b1;
              greq.target       = clamp;
              st_d              = ST_DUTY_WAIT;
            end
            REQ_LEVEL: begin
              en_d[req.channel]  = 1'b0;
              pin_d[req.channel] = req.level_value[0];
            end
            REQ_RECOMP: begin
              ch_d = '0;
              st_d = ST_RC_SCAN;
            end
            REQ_TICK: begin
              if (newc) begin
                cstart_d = req.now_us;
              end
              hp_d  = tk_hp;
              pin_d = tk_pin;
              if (tk_pin != last_q) begin
                last_d  = tk_pin;
                odata_d = tk_pin;
                ovld_d  = 1'b1;
              end
            end
            default: begin
              st_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_DUTY_WAIT: begin
        if (gdone) begin
          st_d = ST_IDLE;
        end
      end
      ST_RC_SCAN: begin
        if (en_q[ch_q]) begin
          gstart = 1'b1;
          st_d   = ST_RC_WAIT;
        end else if (ch_q == 3'(NumCh - 1)) begin
          st_d = ST_IDLE;
        end else begin
          ch_d = ch_q + 3'd1;
        end
      end
      ST_RC_WAIT: begin
        if (gdone) begin
          if (ch_q == 3'(NumCh - 1)) begin
            st_d = ST_IDLE;
          end else begin
            ch_d = ch_q + 3'd1;
            st_d = ST_RC_SCAN;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      ch_q     <= '0;
      cyc_q    <= CycleRst;
      dmax_q   <= DutyRst;
      en_q     <= '0;
      hp_q     <= '0;
      pin_q    <= '0;
      last_q   <= '0;
      cstart_q <= '0;
      ovld_q   <= 1'b0;
      for (int i = 0; i < NumCh; i++) begin
        tgt_q[i] <= '0;
        ont_q[i] <= '0;
      end
    end else begin
      st_q     <= st_d;
      ch_q     <= ch_d;
      en_q     <= en_d;
      hp_q     <= hp_d;
      pin_q    <= pin_d;
      last_q   <= last_d;
      cstart_q <= cstart_d;
      ovld_q   <= ovld_d;
      if (cfg_we_i) begin
        unique case (gcmp_cfg_e'(cfg_idx_i))
          CFG_CYCLE: cyc_q  <= cfg_wdata_i;
          CFG_DMAX:  dmax_q <= cfg_wdata_i[DutyW-1:0];
          default:   cyc_q  <= cyc_q;
        endcase
      end
      if (tgt_we) begin
        tgt_q[req.channel] <= clamp;
      end
      if (gdone) begin
        ont_q[ch_q] <= gres;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    odata_q <= odata_d;
  end

  assign out.valid      = ovld_q;
  assign out.pin_levels = odata_q;

  a_word_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovld_q) |-> $past(acc && req.req_type == REQ_TICK))
    else $error("pin word without a tick");

  a_done_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gdone |-> (st_q == ST_DUTY_WAIT || st_q == ST_RC_WAIT))
    else $error("gamma result while not waiting");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> !req.ready)
    else $error("request taken while busy");

endmodule

/* rtl/gcmp_gamma.sv */
// Iterative gamma 2.2 on-time unit sharing one 32x32 multiplier.
module gcmp_gamma (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  gcmp_pkg::gcmp_greq_t       req_i,
  output logic                       done_o,
  output logic [gcmp_pkg::CycleW-1:0] on_time_o
);
  import gcmp_pkg::*;

  gcmp_gst_e         st_q, st_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [DutyW-1:0]  tgt_q, tgt_d, max_q, max_d, rem_q, rem_d;
  logic [CycleW-1:0] cyc_q, cyc_d, res_q, res_d;
  logic [15:0]       quo_q, quo_d, frac_q, frac_d;
  logic [30:0]       m_q, m_d, r_q, r_d;
  logic [3:0]        p_q, p_d;
  logic [24:0]       e_q, e_d;
  logic [16:0]       g_q, g_d;
  logic              done_q, done_d;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [15:0] rem2;
  logic        qbit;
  logic [15:0] qn;
  logic [31:0] sq;
  logic [20:0] nval;
  logic [6:0]  sh;
  logic [30:0] rsh;
  logic [30:0] ctab [16];

  for (genvar j = 0; j < 16; j++) begin : g_ctab
    localparam logic [63:0] CV = gcmp_c(j + 1);
    assign ctab[j] = CV[30:0];
  end

  assign prod = mul_a * mul_b;
  assign rem2 = {rem_q, 1'b0};
  assign qbit = rem2 >= {1'b0, max_q};
  assign qn   = {quo_q[14:0], qbit};
  assign sq   = prod[61:30];
  assign nval = {(5'd16 - {1'b0, p_q}), 16'd0} - {5'd0, frac_q};
  assign sh   = {1'b0, e_q[21:16]} + 7'd14;
  assign rsh  = r_q >> sh;

  always_comb begin
    unique case (st_q)
      G_SQR: begin
        mul_a = {1'b0, m_q};
        mul_b = {1'b0, m_q};
      end
      G_DIV5: begin
        mul_a = {7'd0, e_q};
        mul_b = {8'd0, Recip5};
      end
      G_EXP: begin
        mul_a = {1'b0, r_q};
        mul_b = {1'b0, ctab[cnt_q]};
      end
      G_MUL: begin
        mul_a = {15'd0, g_q};
        mul_b = {12'd0, cyc_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    tgt_d  = tgt_q;
    max_d  = max_q;
    cyc_d  = cyc_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    m_d    = m_q;
    p_d    = p_q;
    frac_d = frac_q;
    e_d    = e_q;
    r_d    = r_q;
    g_d    = g_q;
    res_d  = res_q;
    done_d = 1'b0;
    unique case (st_q)
      G_IDLE: begin
        if (start_i) begin
          tgt_d = req_i.target;
          max_d = req_i.maxv;
          cyc_d = req_i.cycle;
          cnt_d = '0;
          rem_d = req_i.target;
          quo_d = '0;
          if (req_i.target == '0 || req_i.maxv == '0) begin
            res_d  = '0;
            done_d = 1'b1;
          end else if (req_i.target >= req_i.maxv) begin
            g_d  = 17'd1 << FracBits;
            st_d = G_MUL;
          end else begin
            st_d = G_DIV;
          end
        end
      end
      G_DIV: begin
        rem_d = qbit ? DutyW'(rem2 - {1'b0, max_q}) : rem2[DutyW-1:0];
        quo_d = qn;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          if (qn == '0) begin
            res_d  = '0;
            done_d = 1'b1;
            st_d   = G_IDLE;
          end else begin
            m_d  = {qn, 15'd0};
            p_d  = 4'd15;
            st_d = G_NORM;
          end
        end
      end
      G_NORM: begin
        if (m_q[30]) begin
          cnt_d  = '0;
          frac_d = '0;
          st_d   = G_SQR;
        end else begin
          m_d = {m_q[29:0], 1'b0};
          p_d = p_q - 4'd1;
        end
      end
      G_SQR: begin
        frac_d = {frac_q[14:0], sq[31]};
        m_d    = sq[31] ? sq[31:1] : sq[30:0];
        cnt_d  = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          st_d = G_SCL;
        end
      end
      G_SCL: begin
        e_d  = {nval, 3'd0} + {3'd0, nval, 1'b0} + {4'd0, nval};
        st_d = G_DIV5;
      end
      G_DIV5: begin
        e_d   = {3'd0, prod[47:26]};
        r_d   = 31'd1 << 30;
        cnt_d = '0;
        st_d  = G_EXP;
      end
      G_EXP: begin
        if (e_q[~cnt_q]) begin
          r_d = prod[60:30];
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          st_d = G_SHF;
        end
      end
      G_SHF: begin
        g_d  = (sh >= 7'd63) ? '0 : rsh[16:0];
        st_d = G_MUL;
      end
      G_MUL: begin
        res_d  = prod[35:16];
        done_d = 1'b1;
        st_d   = G_IDLE;
      end
      default: begin
        st_d = G_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= G_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    tgt_q  <= tgt_d;
    max_q  <= max_d;
    cyc_q  <= cyc_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    m_q    <= m_d;
    p_q    <= p_d;
    frac_q <= frac_d;
    e_q    <= e_d;
    r_q    <= r_d;
    g_q    <= g_d;
    res_q  <= res_d;
  end

  assign done_o    = done_q;
  assign on_time_o = res_q;

endmodule

/* sim/gamma_corrected_multichannel_pwm_unit_tb.sv */
// Testbench: gamma PWM unit driven with requests and ticks, pin words checked against a predictor.
`timescale 1ns / 1ps

class pin_scoreboard;
  logic [7:0] pending_q[$];
  int mismatches;
  int errors;

  function void note_word(input logic [7:0] w);
    pending_q.push_back(w);
  endfunction

  function void check_word(input logic [7:0] got);
    logic [7:0] want;
    if (pending_q.size() == 0) begin
      errors++;
      mismatches++;
      if (mismatches <= 10) $display("unexpected pin word %02h", got);
    end else begin
      want = pending_q.pop_front();
      if (want !== got) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) $display("pin word mismatch: expected %02h actual %02h", want, got);
      end
    end
  endfunction
endclass

module gamma_corrected_multichannel_pwm_unit_tb;
  import gcmp_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [19:0] cfg_wdata_i;

  gcmp_req_if req ();
  gcmp_out_if out ();

  gamma_corrected_multichannel_pwm_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req.sink),
    .out        (out.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  pin_scoreboard sb;

  logic [19:0] cyc_time;
  logic [14:0] dmax;
  logic [14:0] target_r [8];
  logic [19:0] on_time_r [8];
  logic [7:0]  pwm_on;
  logic [7:0]  high_ph;
  logic [7:0]  pins;
  logic [7:0]  sent;
  logic [31:0] start_us;
  logic [31:0] now_base;

  int  idle_cycles;
  bit  hold_rx;
  bit  stim_done;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [63:0] root_step(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bv;
    res = '0;
    bv  = 64'd1 << 62;
    while (bv > v) bv = bv >> 2;
    while (bv != 0) begin
      if (v >= res + bv) begin
        v   = v - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] gamma_q16(input logic [14:0] tgt, input logic [14:0] mx);
    logic [63:0] xq, m, frac, n, e, f, k, r, c, sh;
    int p;
    if (tgt == 0 || mx == 0) return 0;
    if (tgt >= mx) return 64'd1 << FracBits;
    xq = ({49'd0, tgt} << FracBits) / mx;
    if (xq == 0) return 0;
    p = 0;
    while (p < 62 && (xq >> (p + 1)) != 0) p++;
    m = xq << (30 - p);
    frac = 0;
    for (int i = 0; i < FracBits; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    n = ((64'(FracBits) - 64'(p)) << FracBits) - frac;
    e = (n * 11) / 5;
    k = e >> FracBits;
    f = e & ((64'd1 << FracBits) - 1);
    r = 64'd1 << 30;
    c = 64'd1 << 29;
    for (int i = 1; i <= FracBits; i++) begin
      c = root_step(c << 30);
      if ((f >> (FracBits - i)) & 1) r = (r * c) >> 30;
    end
    sh = k + 30 - FracBits;
    if (sh >= 63) return 0;
    return r >> sh;
  endfunction

  function automatic logic [19:0] pwm_on_time(input int ch);
    logic [63:0] g;
    g = gamma_q16(target_r[ch], dmax);
    return 20'(((g * cyc_time) >> FracBits));
  endfunction

  function automatic void predict_word(input logic [1:0] rt, input logic [2:0] ch,
                                       input logic [15:0] val, input logic [31:0] now);
    logic [31:0] elapsed;
    case (gcmp_req_e'(rt))
      REQ_DUTY: begin
        pwm_on[ch] = 1'b1;
        target_r[ch] = (val < dmax) ? val[14:0] : dmax;
        on_time_r[ch] = pwm_on_time(ch);
      end
      REQ_LEVEL: begin
        pwm_on[ch] = 1'b0;
        pins[ch] = val[0];
      end
      REQ_RECOMP: begin
        for (int i = 0; i < NumCh; i++)
          if (pwm_on[i]) on_time_r[i] = pwm_on_time(i);
      end
      default: begin
        elapsed = now - start_us;
        if (elapsed >= cyc_time) begin
          start_us = now;
          elapsed = 0;
          for (int i = 0; i < NumCh; i++) begin
            if (pwm_on[i]) begin
              pins[i] = (on_time_r[i] > 0);
              high_ph[i] = (on_time_r[i] > 0);
            end
          end
        end
        for (int i = 0; i < NumCh; i++) begin
          if (pwm_on[i] && high_ph[i] && elapsed >= on_time_r[i] && on_time_r[i] < cyc_time) begin
            pins[i] = 1'b0;
            high_ph[i] = 1'b0;
          end
        end
        if (pins != sent) begin
          sent = pins;
          sb.note_word(pins);
        end
      end
    endcase
  endfunction

  task automatic send_req(input logic [1:0] rt, input logic [2:0] ch,
                          input logic [15:0] val, input logic [31:0] now);
    req.valid       <= 1'b1;
    req.req_type    <= rt;
    req.channel     <= ch;
    req.level_value <= val;
    req.now_us      <= now;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    predict_word(rt, ch, val, now);
  endtask

  task automatic pause_sender();
    req.valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  task automatic write_reg(input gcmp_cfg_e idx, input logic [19:0] v);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    req.valid <= 1'b0;
    repeat (700) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_CYCLE) cyc_time = v;
    else dmax = v[14:0];
  endtask

  task automatic random_phase(input int count);
    int burst;
    int done;
    done = 0;
    while (done < count) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && done < count; b++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: send_req(REQ_DUTY, 3'($urandom), 16'($urandom), 32'($urandom));
          3: send_req(REQ_LEVEL, 3'($urandom), 16'($urandom), 32'($urandom));
          4: send_req(REQ_RECOMP, 3'($urandom), 16'($urandom), 32'($urandom));
          5: send_req(REQ_TICK, 3'($urandom), 16'($urandom), 32'($urandom));
          default: begin
            now_base = now_base + $urandom_range(0, cyc_time / 3 + 2);
            send_req(REQ_TICK, 3'($urandom), 16'($urandom), now_base);
          end
        endcase
        done++;
      end
      if ($urandom_range(0, 3) != 0) pause_sender();
    end
    req.valid <= 1'b0;
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = 1'b0;
    cfg_wdata_i = '0;
    req.valid = 1'b0;
    req.req_type = '0;
    req.channel = '0;
    req.level_value = '0;
    req.now_us = '0;
    stim_done = 1'b0;
    cyc_time = CycleRst;
    dmax = DutyRst;
    for (int i = 0; i < 8; i++) begin
      target_r[i] = '0;
      on_time_r[i] = '0;
    end
    pwm_on = '0;
    high_ph = '0;
    pins = '0;
    sent = '0;
    start_us = '0;
    now_base = 32'd5;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(REQ_DUTY, 3'd0, 16'd0, 32'd0);
    send_req(REQ_DUTY, 3'd1, 16'hFFFF, 32'hFFFF_FFFF);
    send_req(REQ_DUTY, 3'd2, 16'd1, 32'd0);
    send_req(REQ_DUTY, 3'd3, 16'd128, 32'd0);
    send_req(REQ_DUTY, 3'd7, 16'd254, 32'd0);
    send_req(REQ_LEVEL, 3'd4, 16'd1, 32'd0);
    send_req(REQ_LEVEL, 3'd5, 16'hFFFF, 32'd0);
    send_req(REQ_LEVEL, 3'd4, 16'hFFFE, 32'd0);
    send_req(REQ_TICK, 3'd0, 16'd0, 32'd10000);
    send_req(REQ_TICK, 3'd7, 16'hFFFF, 32'd10100);
    send_req(REQ_TICK, 3'd0, 16'd0, 32'd16000);
    send_req(REQ_LEVEL, 3'd1, 16'd0, 32'd0);
    send_req(REQ_DUTY, 3'd1, 16'd200, 32'd0);
    send_req(REQ_RECOMP, 3'd0, 16'd0, 32'd0);
    send_req(REQ_TICK, 3'd0, 16'd0, 32'hFFFF_FFFF);
    send_req(REQ_TICK, 3'd0, 16'd0, 32'd20);
    req.valid <= 1'b0;

    write_reg(CFG_DMAX, 20'd24999);
    write_reg(CFG_CYCLE, 20'd1000000);
    send_req(REQ_DUTY, 3'd6, 16'd24998, 32'd0);
    send_req(REQ_DUTY, 3'd2, 16'd3, 32'd0);
    send_req(REQ_RECOMP, 3'd0, 16'd0, 32'd0);
    random_phase(120);
    write_reg(CFG_DMAX, 20'd1);
    write_reg(CFG_CYCLE, 20'd40);
    send_req(REQ_RECOMP, 3'd0, 16'd0, 32'd0);
    random_phase(120);
    write_reg(CFG_DMAX, 20'd0);
    write_reg(CFG_CYCLE, 20'd0);
    random_phase(60);
    write_reg(CFG_DMAX, 20'd255);
    write_reg(CFG_CYCLE, 20'd300);
    hold_rx = 1'b1;
    random_phase(200);
    write_reg(CFG_DMAX, 20'd1000);
    write_reg(CFG_CYCLE, 20'd2000);
    random_phase(200);
    stim_done = 1'b1;
  end

  initial begin
    int stretch;
    hold_rx = 1'b0;
    out.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_rx) begin
        hold_rx = 1'b0;
        out.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      stretch = $urandom_range(1, 20);
      case ($urandom_range(0, 2))
        0: begin
          out.ready <= 1'b1;
          repeat (stretch) @(posedge clk_i);
        end
        1: begin
          out.ready <= 1'b0;
          repeat (stretch) @(posedge clk_i);
        end
        default: begin
          for (int i = 0; i < stretch; i++) begin
            out.ready <= i[0];
            @(posedge clk_i);
          end
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out.valid && out.ready) sb.check_word(out.pin_levels);
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((req.valid && req.ready) || (out.valid && out.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 20000) begin
        $display("status: fail");
        $finish;
      end
      if (stim_done && sb.pending_q.size() == 0) begin
        repeat (100) @(posedge clk_i);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
          $display("status: pass");
        end else begin
          $display("status: fail");
        end
        $finish;
      end
    end
  end
endmodule
